// ===== rtl/core/grid_neighbor_cell_ranges_defines.svh =====
// Assertion macros shared by the grid neighbor cell range RTL.
// Expects signals named clk and arst_n in the using module.
`ifndef GRID_NEIGHBOR_CELL_RANGES_DEFINES_SVH
`define GRID_NEIGHBOR_CELL_RANGES_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define GNCR_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define GNCR_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gncr_pkg.sv =====
// Package for the grid neighbor cell range block: widths, codes, types.
// No dependencies.
`timescale 1ns / 1ps
package gncr_pkg;
	localparam int MAX_CELLS  = 4096;
	localparam int SLOT_W     = 13;
	localparam int CELL_W     = 12;
	localparam int PART_W     = 16;
	localparam int COORD_W    = 16;
	localparam int CNT_W      = 5;
	localparam int CFG_ADDR_W = 3;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 48;
	localparam int HOME_W     = 26;
	localparam int IDX_W      = 28;

	// Divider lanes
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_Z = 2;
	localparam int LANE_B = 3;
	localparam int LANES  = 4;

	// Configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_SPACING = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BOUND_X = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BOUND_Y = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_BOUND_Z = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_CELLS_X = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_CELLS_Z = 3'd5;

	// Item kinds
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef logic [LANES-1:0][COORD_W-1:0] lanes_t;

	typedef struct packed {
		logic               start;
		logic [COORD_W-1:0] divisor;
		lanes_t             dividend;
	} div_req_t;

	typedef struct packed {
		logic   done;
		lanes_t quo;
	} div_rsp_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_idx;
		logic [PART_W-1:0] rend;
		logic [PART_W-1:0] rstart;
	} range_t;
endpackage

// ===== rtl/core/gncr_div.sv =====
// Four-lane restoring divider, one quotient bit per lane per cycle.
// Depends on gncr_pkg.
`timescale 1ns / 1ps
module gncr_div import gncr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [LANES-1:0][COORD_W:0]   rem_q;
	lanes_t                        quo_q;
	logic [COORD_W-1:0]            dvs_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [LANES-1:0][COORD_W:0]   rem_n;
	lanes_t                        quo_n;
	logic [COORD_W:0]              trial;

	// One restoring step per lane
	always_comb begin
		trial = '0;
		for (int i = 0; i < LANES; i++) begin
			trial = {rem_q[i][COORD_W-1:0], quo_q[i][COORD_W-1]};
			if (trial >= {1'b0, dvs_q}) begin
				rem_n[i] = trial - {1'b0, dvs_q};
				quo_n[i] = {quo_q[i][COORD_W-2:0], 1'b1};
			end else begin
				rem_n[i] = trial;
				quo_n[i] = {quo_q[i][COORD_W-2:0], 1'b0};
			end
		end
	end

	// Control: load on start, count sixteen steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(COORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

// ===== rtl/core/grid_neighbor_cell_ranges.sv =====
// Query: the divider runs sixteen steps, then ST_HOME1..3 form the home
// cell, the walk visits each neighbor with a wait state per range read
// (n <= 27 ranges read), and a flush closes; the next input transfer is
// taken in ST_IDLE, and only an output stall lengthens wait and flush.
// A write item is taken in ST_IDLE. Reset clears control and configuration
// registers, not the table. Reset: asynchronous, active low on arst_n.
`timescale 1ns / 1ps
`include "grid_neighbor_cell_ranges_defines.svh"
module grid_neighbor_cell_ranges import gncr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pos_x, pos_y, pos_z, entry_index, entry_value, zero pad
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// range_start, range_end, cell_index, zero pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [COORD_W-1:0]    cfg_wdata
);
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_DIV   = 8'b0000_0010,
		ST_HOME1 = 8'b0000_0100,
		ST_HOME2 = 8'b0000_1000,
		ST_HOME3 = 8'b0001_0000,
		ST_WALK  = 8'b0010_0000,
		ST_WAIT  = 8'b0100_0000,
		ST_FLUSH = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [COORD_W-1:0] spacing_q, bound_x_q, bound_y_q, bound_z_q;
	logic [4:0]         cells_x_q, cells_z_q;
	logic [COORD_W-1:0] sp_eff;
	logic [4:0]         nx_eff, nz_eff;

	logic [COORD_W-1:0] px, py, pz, ent_val;
	logic [SLOT_W-1:0]  ent_idx;
	logic               in_xfer;

	logic [PART_W-1:0] table_mem [MAX_CELLS+1];
	logic [PART_W-1:0] rd_start_s2, rd_end_s2;
	logic [CELL_W-1:0] cell_s2;

	div_req_t dreq;
	div_rsp_t drsp;

	logic [5:0]         skip_q; // xm, xp, ym, yp, zm, zp
	logic [3:0]         cx_q, cz_q;
	logic [COORD_W-1:0] cy_q;
	logic [8:0]         nxnz_q;
	logic [20:0]        t_q;
	logic [HOME_W-1:0]  home_q;
	logic [1:0]         dx_q, dy_q, dz_q;
	logic               end_q;

	logic signed [IDX_W-1:0] offx, offy, offz, idx_c;
	logic                    skip_c, cand_ok, at_end, rd_en;

	range_t hold_q, out_q;
	logic   hold_v_q, out_v_q, out_last_q;
	logic   out_free;

	// Unpack the input transfer
	assign px      = s_axis_tdata[15:0];
	assign py      = s_axis_tdata[31:16];
	assign pz      = s_axis_tdata[47:32];
	assign ent_idx = s_axis_tdata[60:48];
	assign ent_val = s_axis_tdata[76:61];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// Clamp the configuration
	assign sp_eff = (spacing_q == '0) ? COORD_W'(1) : spacing_q;
	assign nx_eff = (cells_x_q == '0) ? 5'd1 : ((cells_x_q > 5'd16) ? 5'd16 : cells_x_q);
	assign nz_eff = (cells_z_q == '0) ? 5'd1 : ((cells_z_q > 5'd16) ? 5'd16 : cells_z_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= 16'd256;
			bound_x_q <= 16'd4096;
			bound_y_q <= 16'd4096;
			bound_z_q <= 16'd4096;
			cells_x_q <= 5'd16;
			cells_z_q <= 5'd16;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SPACING: spacing_q <= cfg_wdata;
				REG_BOUND_X: bound_x_q <= cfg_wdata;
				REG_BOUND_Y: bound_y_q <= cfg_wdata;
				REG_BOUND_Z: bound_z_q <= cfg_wdata;
				REG_CELLS_X: cells_x_q <= cfg_wdata[4:0];
				REG_CELLS_Z: cells_z_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	// Divider request: three positions and the y bound
	assign dreq.start    = in_xfer && (s_axis_tuser == CMD_QUERY);
	assign dreq.divisor  = sp_eff;
	assign dreq.dividend = {bound_y_q, pz, py, px};

	gncr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// Neighbor offset for the current walk position
	always_comb begin
		case (dx_q)
			2'd0:    offx = -IDX_W'(1);
			2'd2:    offx = IDX_W'(1);
			default: offx = '0;
		endcase
		case (dz_q)
			2'd0:    offz = -$signed(IDX_W'(nx_eff));
			2'd2:    offz = $signed(IDX_W'(nx_eff));
			default: offz = '0;
		endcase
		case (dy_q)
			2'd0:    offy = -$signed(IDX_W'(nxnz_q));
			2'd2:    offy = $signed(IDX_W'(nxnz_q));
			default: offy = '0;
		endcase
	end

	assign idx_c  = $signed(IDX_W'(home_q)) + offx + offy + offz;
	assign skip_c = (dx_q == 2'd0 && skip_q[0]) || (dx_q == 2'd2 && skip_q[1]) ||
	                (dy_q == 2'd0 && skip_q[2]) || (dy_q == 2'd2 && skip_q[3]) ||
	                (dz_q == 2'd0 && skip_q[4]) || (dz_q == 2'd2 && skip_q[5]);
	assign cand_ok = !skip_c && (idx_c[IDX_W-1:CELL_W] == '0);
	assign at_end  = (dx_q == 2'd2) && (dz_q == 2'd2) && (dy_q == 2'd2);
	assign rd_en   = (state_q == ST_WALK) && cand_ok;

	assign out_free = !out_v_q || m_axis_tready;

	// Table memory: write port from input, two read ports for the range
	always_ff @(posedge clk) begin
		if (in_xfer && (s_axis_tuser == CMD_WRITE) && (ent_idx <= SLOT_W'(MAX_CELLS)))
			table_mem[ent_idx] <= ent_val;
		if (rd_en) begin
			rd_start_s2 <= table_mem[{1'b0, idx_c[CELL_W-1:0]}];
			rd_end_s2   <= table_mem[{1'b0, idx_c[CELL_W-1:0]} + SLOT_W'(1)];
			cell_s2     <= idx_c[CELL_W-1:0];
		end
	end

	// Query datapath registers
	always_ff @(posedge clk) begin
		if (dreq.start) begin
			skip_q[0] <= px < sp_eff;
			skip_q[1] <= ({1'b0, px} + {1'b0, sp_eff}) >= {1'b0, bound_x_q};
			skip_q[2] <= py < sp_eff;
			skip_q[3] <= ({1'b0, py} + {1'b0, sp_eff}) >= {1'b0, bound_y_q};
			skip_q[4] <= pz < sp_eff;
			skip_q[5] <= ({1'b0, pz} + {1'b0, sp_eff}) >= {1'b0, bound_z_q};
		end
		if (state_q == ST_HOME1) begin
			cx_q   <= (drsp.quo[LANE_X] > COORD_W'(nx_eff - 5'd1)) ?
			          4'(nx_eff - 5'd1) : drsp.quo[LANE_X][3:0];
			cz_q   <= (drsp.quo[LANE_Z] > COORD_W'(nz_eff - 5'd1)) ?
			          4'(nz_eff - 5'd1) : drsp.quo[LANE_Z][3:0];
			cy_q   <= (drsp.quo[LANE_Y] > drsp.quo[LANE_B]) ?
			          drsp.quo[LANE_B] : drsp.quo[LANE_Y];
			nxnz_q <= 9'(nx_eff) * 9'(nz_eff);
		end
		if (state_q == ST_HOME2)
			t_q <= 21'(cz_q) + 21'(nz_eff) * 21'(cy_q);
		if (state_q == ST_HOME3)
			home_q <= HOME_W'(cx_q) + HOME_W'(nx_eff) * HOME_W'(t_q);
	end

	// Sequencer, walk counters and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dx_q       <= '0;
			dy_q       <= '0;
			dz_q       <= '0;
			end_q      <= 1'b0;
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (m_axis_tready)
				out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (dreq.start)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (drsp.done)
						state_q <= ST_HOME1;
				end
				ST_HOME1: state_q <= ST_HOME2;
				ST_HOME2: state_q <= ST_HOME3;
				ST_HOME3: begin
					dx_q    <= '0;
					dy_q    <= '0;
					dz_q    <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					// advance x fastest, then z, then y
					if (dx_q == 2'd2) begin
						dx_q <= '0;
						if (dz_q == 2'd2) begin
							dz_q <= '0;
							dy_q <= dy_q + 2'd1;
						end else begin
							dz_q <= dz_q + 2'd1;
						end
					end else begin
						dx_q <= dx_q + 2'd1;
					end
					end_q <= at_end;
					if (cand_ok)
						state_q <= ST_WAIT;
					else if (at_end)
						state_q <= ST_FLUSH;
				end
				ST_WAIT: begin
					// push the held range out, keep the fresh one back
					if (!hold_v_q || out_free) begin
						if (hold_v_q) begin
							out_v_q    <= 1'b1;
							out_last_q <= 1'b0;
						end
						hold_v_q <= 1'b1;
						state_q  <= end_q ? ST_FLUSH : ST_WALK;
					end
				end
				ST_FLUSH: begin
					if (!hold_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_v_q    <= 1'b1;
						out_last_q <= 1'b1;
						hold_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload of the hold and output stages
	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && (!hold_v_q || out_free)) begin
			hold_q <= '{cell_idx: cell_s2, rend: rd_end_s2, rstart: rd_start_s2};
			if (hold_v_q)
				out_q <= hold_q;
		end
		if (state_q == ST_FLUSH && hold_v_q && out_free)
			out_q <= hold_q;
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0, out_q.cell_idx, out_q.rend, out_q.rstart};

	`GNCR_ASSERT_IMP(a_div_done_in_div, drsp.done, state_q == ST_DIV, "done outside division")
	`GNCR_ASSERT_NXT(a_read_then_wait, rd_en, state_q == ST_WAIT, "read not followed by wait")
	`GNCR_ASSERT_IMP(a_hold_in_walk, hold_v_q, state_q[7:5] != 3'b000, "held range outside walk")
	`GNCR_ASSERT_NXT(a_flush_clears, state_q == ST_FLUSH && out_free, !hold_v_q, "flush kept a range")
endmodule
